>>> sv/assert_macros.svh
// Assertion helpers, sampled on i_clk and disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define JSE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`define JSE_ASSERT_NEXT(label, ante, cons, msg) \
    `JSE_ASSERT(label, (ante) |=> (cons), msg)

`endif

>>> sv/jse_pkg.sv
`default_nettype none

package jse_pkg;

    localparam int JSE_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_item;

    typedef enum logic [1:0] {
        KIND_COPY,      // the byte itself
        KIND_PREFIX,    // backslash, then the byte
        KIND_UNI        // \u00 and two hex digits
    } t_kind;

    // One classified item: what the back end has to write out.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] c0;     // copied byte, or high hex digit
        logic [7:0] c1;     // low hex digit
    } t_desc;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_UP_B   = 8'h42;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    localparam logic [2:0] UNI_LAST_POS = 3'd5;

    function automatic logic [7:0] hex_lower(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'h0, v};
        end else begin
            r = 8'h57 + {4'h0, v};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/jse_front.sv
`default_nettype none

module jse_front import jse_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire logic     i_cfg_wdata,
    input  wire logic     i_push,
    input  wire t_in_item i_item,
    input  wire logic     i_q_full,
    output logic          o_q_push,
    output t_desc         o_desc
);

    logic       r_list_mode;
    logic [1:0] r_raw_left;
    logic [1:0] n_raw_left;
    logic [1:0] lead_len;
    logic [7:0] b;

    assign b        = i_item.in_byte;
    assign o_q_push = i_push && !i_q_full;

    // run length after a UTF-8 lead byte
    always_comb begin
        if (!b[5]) begin
            lead_len = 2'd1;
        end else if (!b[4]) begin
            lead_len = 2'd2;
        end else begin
            lead_len = 2'd3;
        end
    end

    always_comb begin
        o_desc.kind = KIND_COPY;
        o_desc.c0   = b;
        o_desc.c1   = 8'h00;
        n_raw_left  = r_raw_left;
        priority if (r_raw_left != 2'd0) begin
            n_raw_left = r_raw_left - 2'd1;
        end else if (b == CH_BSLASH || b == CH_QUOTE) begin
            o_desc.kind = KIND_PREFIX;
        end else if (b < CTRL_LIMIT) begin
            o_desc.kind = KIND_UNI;
            o_desc.c0   = hex_lower(b[7:4]);
            o_desc.c1   = hex_lower(b[3:0]);
        end else if (r_list_mode && b == CH_TILDE) begin
            o_desc.kind = KIND_UNI;
            o_desc.c0   = CH_SEVEN;
            o_desc.c1   = CH_UP_E;
        end else if (r_list_mode && b == CH_SEMI) begin
            o_desc.kind = KIND_UNI;
            o_desc.c0   = CH_THREE;
            o_desc.c1   = CH_UP_B;
        end else if (b[7:6] == 2'b11) begin
            n_raw_left = lead_len;
        end else begin
            n_raw_left = 2'd0;
        end
        if (i_item.end_of_text) begin
            n_raw_left = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_mode <= 1'b0;
            r_raw_left  <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_list_mode <= i_cfg_wdata;
            end
            if (o_q_push) begin
                r_raw_left <= n_raw_left;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/jse_queue.sv
`default_nettype none

module jse_queue import jse_pkg::*; #(
    parameter int DEPTH = JSE_QUEUE_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_desc i_desc,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_desc      o_desc
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_desc         r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_desc  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/jse_back.sv
`default_nettype none

`include "assert_macros.svh"

module jse_back import jse_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_empty,
    input  wire t_desc i_desc,
    output logic       o_q_pop,
    input  wire logic  i_pop,
    output logic       o_empty,
    output t_out_item  o_item
);

    logic       r_valid;
    t_out_item  r_item;
    logic [2:0] r_pos;
    logic [2:0] n_pos;
    logic [7:0] cur_byte;
    logic       cur_last;
    logic       load;

    // byte at r_pos of the head item
    always_comb begin
        cur_byte = i_desc.c0;
        cur_last = 1'b1;
        unique case (i_desc.kind)
            KIND_COPY: begin
                cur_byte = i_desc.c0;
                cur_last = 1'b1;
            end
            KIND_PREFIX: begin
                cur_byte = (r_pos == 3'd0) ? CH_BSLASH : i_desc.c0;
                cur_last = (r_pos != 3'd0);
            end
            KIND_UNI: begin
                unique case (r_pos)
                    3'd0:    cur_byte = CH_BSLASH;
                    3'd1:    cur_byte = CH_LOW_U;
                    3'd2:    cur_byte = CH_ZERO;
                    3'd3:    cur_byte = CH_ZERO;
                    3'd4:    cur_byte = i_desc.c0;
                    default: cur_byte = i_desc.c1;
                endcase
                cur_last = (r_pos == UNI_LAST_POS);
            end
            default: begin
                cur_byte = i_desc.c0;
                cur_last = 1'b1;
            end
        endcase
    end

    assign load    = !i_q_empty && (!r_valid || i_pop);
    assign o_q_pop = load && cur_last;
    assign n_pos   = cur_last ? 3'd0 : r_pos + 3'd1;
    assign o_empty = !r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.out_byte    <= cur_byte;
            r_item.last_of_run <= cur_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 3'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_pos   <= n_pos;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    `JSE_ASSERT(a_mid_item_has_head, (r_pos != 3'd0) |-> !i_q_empty, "head item lost mid run")
    `JSE_ASSERT(a_mid_item_not_copy, (r_pos != 3'd0) |-> (i_desc.kind != KIND_COPY), "copy item past first byte")
    `JSE_ASSERT_NEXT(a_pop_restarts, o_q_pop, r_pos == 3'd0, "position not cleared after item done")

endmodule

`default_nettype wire

>>> sv/json_string_escaper_unit.sv
// JSON string escaper: one text byte in, its escaped form out, one byte per item.
// Input side is a queue write port: drive i_data and raise push; the item is
// taken at a clock edge where push is high and full is low.
// Output side is a queue read port: while empty is low, o_data holds the
// oldest escaped byte; raising pop takes it at that edge. last_of_run marks
// the final output byte of each input byte.
// An input byte yields 1 byte (plain copy or raw UTF-8 run), 2 bytes (quote,
// backslash) or 6 bytes (\u00xx for control bytes, tilde and semicolon in
// list mode). Each item is registered in the queue, then in the output register.
// The output register emits one byte per cycle while pop is high, so the input
// rate is set by the length of each byte's escape sequence.
// A classifier and a QUEUE_DEPTH-entry queue decouple input from output; when
// pop stays low the output holds, the queue fills, and full rises.
// i_cfg_we/i_cfg_wdata write list_mode; write it only while the block is idle.
// Synchronous reset clears the queue, output register, raw-run count and
// list_mode.
`default_nettype none

module json_string_escaper_unit import jse_pkg::*; #(
    parameter int QUEUE_DEPTH = JSE_QUEUE_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire logic     i_cfg_wdata,
    input  wire logic     push,
    output logic          full,
    input  wire t_in_item i_data,
    output logic          empty,
    input  wire logic     pop,
    output t_out_item     o_data
);

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    t_desc front_desc;
    t_desc head_desc;

    assign full = q_full;

    jse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_item      (i_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_desc      (front_desc)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (front_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_desc  (head_desc)
    );

    jse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_desc    (head_desc),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_item    (o_data)
    );

endmodule

`default_nettype wire
